// ===== rtl/core/swr_pkg.sv =====
// Shared types and constants of the sliding-window receiver.
// Command and status groups between controller and datapath; result kind codes.
// No dependencies.
package swr_pkg;

  // result kinds on the output channel
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // ack code before anything has been delivered (-1)
  localparam logic [3:0] ACK_NONE = 4'hF;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming packet
    logic store;     // buffer the latched packet if it is acceptable
    logic rd_en;     // read a slot payload
    logic load_del;  // load a delivery beat, slide the window
    logic load_ack;  // load the ack beat
  } swr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drain;       // latched packet is valid and in order
    logic next_valid;  // slot after the head is filled
    logic out_free;    // output register can take a beat this cycle
  } swr_sts_t;

endpackage

// ===== rtl/core/swr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/swr_ctrl.sv =====
// Sequencing state machine of the sliding-window receiver.
// Depends on swr_pkg for the command and status groups.
module swr_ctrl
  import swr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  swr_sts_t sts_i,
  output swr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_DELIVER = 3'd3;
  localparam logic [2:0] S_ACK     = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.store = 1'b1;
        state_d     = sts_i.drain ? S_READ : S_ACK;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DELIVER;
      end
      S_DELIVER: begin
        // hold until the output register frees up, then chain the next read
        if (sts_i.out_free) begin
          cmd_o.load_del = 1'b1;
          if (sts_i.next_valid) begin
            cmd_o.rd_en = 1'b1;
          end else begin
            state_d = S_ACK;
          end
        end
      end
      S_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.load_ack = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/core/swr_dp.sv =====
// Datapath of the sliding-window receiver: packet latch, window state,
// slot payload RAM and output register.
// Depends on swr_pkg and swr_ram.
module swr_dp
  import swr_pkg::*;
#(
  parameter int SEQ_SPACE    = 8,
  parameter int WINDOW       = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swr_cmd_t           cmd_i,
  output swr_sts_t           sts_o,
  input  logic [2:0]         seq_num_i,
  input  logic               checksum_ok_i,
  input  logic [63:0]        payload_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               kind_o,
  output logic [63:0]        payload_res_o,
  output logic signed [3:0]  ack_num_o,
  output logic               last_o
);

  localparam int SW = $clog2(SEQ_SPACE);
  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW = ((SW > IW) ? SW : IW) + 1;

  // latched packet
  logic [2:0]              seq_q;
  logic                    ok_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // window state
  logic [WINDOW-1:0] valid_q;
  logic [IW-1:0]     head_q;
  logic [SW-1:0]     exp_q;
  logic [3:0]        ack_q;

  // output register
  logic        out_valid_q;
  logic        out_kind_q;
  logic [63:0] out_pay_q;
  logic [3:0]  out_ack_q;
  logic        out_last_q;

  logic                    in_range;
  logic [SW-1:0]           seq_w;
  logic [SW:0]             diff;
  logic [SW-1:0]           off_w;
  logic                    in_win;
  logic [AW-1:0]           sum;
  logic [IW-1:0]           phys;
  logic                    store_ok;
  logic [IW-1:0]           head_nx;
  logic [SW-1:0]           exp_nx;
  logic [IW-1:0]           raddr;
  logic [PAYLOAD_BITS-1:0] rdata;

  // offset of the packet from the window head, modulo the sequence space
  always_comb begin
    in_range = 32'(seq_q) < SEQ_SPACE;
    seq_w    = SW'(seq_q);
    diff     = {1'b0, seq_w} - {1'b0, exp_q};
    if (seq_w < exp_q) begin
      diff = diff + (SW+1)'(SEQ_SPACE);
    end
    off_w  = diff[SW-1:0];
    in_win = 32'(off_w) < WINDOW;
    sum    = AW'(head_q) + AW'(off_w);
    if (sum >= AW'(WINDOW)) begin
      sum = sum - AW'(WINDOW);
    end
    phys     = sum[IW-1:0];
    store_ok = ok_q && in_range && in_win && !valid_q[phys];
  end

  assign head_nx = (head_q == IW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
  assign exp_nx  = (exp_q == SW'(SEQ_SPACE - 1)) ? '0 : exp_q + 1'b1;
  assign raddr   = cmd_i.load_del ? head_nx : head_q;

  assign sts_o.drain      = ok_q && in_range && (off_w == '0);
  assign sts_o.next_valid = (WINDOW > 1) && valid_q[head_nx];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seq_q <= seq_num_i;
      ok_q  <= checksum_ok_i;
      pay_q <= payload_i[PAYLOAD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      head_q  <= '0;
      exp_q   <= '0;
      ack_q   <= ACK_NONE;
    end else begin
      if (cmd_i.store && store_ok) begin
        valid_q[phys] <= 1'b1;
      end
      if (cmd_i.load_del) begin
        valid_q[head_q] <= 1'b0;
        head_q          <= head_nx;
        exp_q           <= exp_nx;
        ack_q           <= 4'(exp_q);
      end
    end
  end

  swr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store && store_ok),
    .waddr_i (phys),
    .wdata_i (pay_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_del || cmd_i.load_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_del) begin
      out_kind_q <= KIND_DELIVER;
      out_pay_q  <= 64'(rdata);
      out_ack_q  <= '0;
      out_last_q <= 1'b0;
    end else if (cmd_i.load_ack) begin
      out_kind_q <= KIND_ACK;
      out_pay_q  <= '0;
      out_ack_q  <= ack_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign payload_res_o = out_pay_q;
  assign ack_num_o     = $signed(out_ack_q);
  assign last_o        = out_last_q;

  // never slide past an empty head slot
  a_del_head_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_del |-> valid_q[head_q])
    else $error("delivery from an empty head slot");

  // a chained read must target a filled slot
  a_chain_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_del && cmd_i.rd_en) |-> valid_q[head_nx])
    else $error("chained read of an empty slot");

  // an in-order packet leaves the head slot filled for the drain
  a_drain_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.store && sts_o.drain) |=> valid_q[head_q])
    else $error("in-order packet not buffered at head");

  // no beat is loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_del || cmd_i.load_ack) |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten");

endmodule

// ===== rtl/core/sliding_window_receiver_top.sv =====
// Sliding-window receiver: one packet a beat in, deliveries then one ack out.
// A packet is captured in IDLE and judged in DECIDE; one that only acks goes on to ACK,
// an in-order one through READ to DELIVER before its first result enters the output register.
// A new packet is taken only in IDLE, after the ack beat of the last one is loaded; the
// controller emits one beat per cycle, while the single output register is free.
// Reset: all slots empty, expected sequence 0, ack -1; no clearing pass is needed.
module sliding_window_receiver_top
  import swr_pkg::*;
#(
  parameter int SEQ_SPACE    = 8,
  parameter int WINDOW       = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // packet channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        seq_num_i,
  input  logic              checksum_ok_i,
  input  logic [63:0]       payload_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic [63:0]       payload_res_o,
  output logic signed [3:0] ack_num_o,
  output logic              last_o
);

  // The controller steps IDLE -> DECIDE, then either straight to ACK (corrupt,
  // duplicate, out-of-window or out-of-order packets) or through READ and a run
  // of DELIVER beats while the slot after the head is filled. Slot payloads
  // live in a RAM addressed as a ring from the head pointer, so the window
  // slides by advancing that pointer; the valid bits stay in flops.
  swr_cmd_t cmd;
  swr_sts_t sts;

  swr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The output register parts the two sides: a waiting ack beat does not
  // stop the next packet being accepted.
  swr_dp #(
    .SEQ_SPACE    (SEQ_SPACE),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .seq_num_i     (seq_num_i),
    .checksum_ok_i (checksum_ok_i),
    .payload_i     (payload_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .payload_res_o (payload_res_o),
    .ack_num_o     (ack_num_o),
    .last_o        (last_o)
  );

endmodule
